FILE: design/ngc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngc_pkg
// Shared types and constants of the normalized gear chunker.
// ----------------------------------------------------------------------------
package ngc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MIN_SIZE    = 3'd0;
  localparam logic [2:0] REG_NORMAL_SIZE = 3'd1;
  localparam logic [2:0] REG_MAX_SIZE    = 3'd2;
  localparam logic [2:0] REG_STRICT_MASK = 3'd3;
  localparam logic [2:0] REG_LOOSE_MASK  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [15:0] MIN_SIZE_RST    = 16'(6 * 1024);
  localparam logic [15:0] NORMAL_SIZE_RST = 16'(8 * 1024);
  localparam logic [15:0] MAX_SIZE_RST    = 16'(8192 * 4);
  localparam logic [63:0] STRICT_MASK_RST = 64'h0000_f907_0353_0000;
  localparam logic [63:0] LOOSE_MASK_RST  = 64'h0000_d900_0353_0000;

  // Input kinds on tuser
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Chunk end causes
  localparam logic [1:0] CAUSE_CUT = 2'd0;
  localparam logic [1:0] CAUSE_MAX = 2'd1;
  localparam logic [1:0] CAUSE_END = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;

  // Result buffer in the back end
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_BITS = 2;

  typedef struct packed {
    logic [15:0] min_size;
    logic [15:0] normal_size;
    logic [15:0] max_size;
    logic [63:0] strict_mask;
    logic [63:0] loose_mask;
  } cfg_t;

  // Classified data byte: its gear word and end-of-stream mark
  typedef struct packed {
    logic [63:0] gear;
    logic        eos;
  } gear_item_t;

  typedef struct packed {
    logic [15:0] chunk_length;
    logic [1:0]  end_cause;
    logic        last_of_run;
  } result_t;

endpackage
`default_nettype wire

FILE: design/ngc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngc_front
// Accepts items, loads the gear table and looks up the gear word of each
// data byte; the looked-up item waits in a register until the queue takes it.
// ----------------------------------------------------------------------------
module ngc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               opcode,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_stream,
  input  wire logic [7:0]         table_index,
  input  wire logic [63:0]        table_word,
  output logic                    item_valid,
  input  wire logic               item_ready,
  output ngc_pkg::gear_item_t     item
);

  logic [63:0] gear_mem [256];
  logic        rd_valid;
  logic        rd_eos;
  logic [63:0] rd_gear;
  logic        accept;
  logic        push;

  assign push     = rd_valid && item_ready;
  assign in_ready = !rd_valid || item_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept && opcode == ngc_pkg::OP_LOAD) begin
      gear_mem[table_index] <= table_word;
    end
    // hold the read data while the item waits for the queue
    if (accept && opcode == ngc_pkg::OP_DATA) begin
      rd_gear <= gear_mem[data_byte];
      rd_eos  <= end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (accept && opcode == ngc_pkg::OP_DATA) || (rd_valid && !push);
    end
  end

  assign item_valid = rd_valid;
  assign item.gear  = rd_gear;
  assign item.eos   = rd_eos;

endmodule
`default_nettype wire

FILE: design/ngc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngc_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module ngc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_valid,
  output logic                       wr_ready,
  input  wire ngc_pkg::gear_item_t   wr_item,
  output logic                       rd_valid,
  input  wire logic                  rd_ready,
  output ngc_pkg::gear_item_t        rd_item
);

  ngc_pkg::gear_item_t                 slots [ngc_pkg::QUEUE_DEPTH];
  logic [ngc_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr;
  logic [ngc_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr;
  logic [ngc_pkg::QUEUE_PTR_BITS:0]    count;
  logic                                do_wr;
  logic                                do_rd;

  assign wr_ready = count != (ngc_pkg::QUEUE_PTR_BITS+1)'(ngc_pkg::QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/ngc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngc_back
// Chunk state: fingerprint update, cut and size decisions, result buffer.
// ----------------------------------------------------------------------------
module ngc_back #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ngc_pkg::cfg_t         cfg,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire ngc_pkg::gear_item_t   item,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output ngc_pkg::result_t           res
);

  localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [63:0]                       fp;
  logic [LENGTH_BITS-1:0]            pos;
  ngc_pkg::result_t                  res_buf [ngc_pkg::RES_DEPTH];
  logic [ngc_pkg::RES_PTR_BITS-1:0]  wr_ptr;
  logic [ngc_pkg::RES_PTR_BITS-1:0]  rd_ptr;
  logic [ngc_pkg::RES_PTR_BITS:0]    count;

  logic                    take;
  logic                    pop_res;
  logic                    close_a;
  logic [LENGTH_BITS-1:0]  pos_a;
  logic [63:0]             fp_a;
  logic                    fp_on;
  logic [63:0]             fp_sh;
  logic [63:0]             mask;
  logic                    cut;
  logic [LENGTH_BITS-1:0]  pos_b;
  logic [63:0]             fp_b;
  logic [LENGTH_BITS-1:0]  pos_c;
  logic                    close_b;
  logic                    first_v;
  logic [LENGTH_BITS-1:0]  pos_next;
  logic [63:0]             fp_next;
  ngc_pkg::result_t        first_r;
  ngc_pkg::result_t        second_r;
  logic [1:0]              n_res;

  // take an item only with room for two results
  assign item_ready = count <= (ngc_pkg::RES_PTR_BITS+1)'(ngc_pkg::RES_DEPTH - 2);
  assign take       = item_valid && item_ready;
  assign res_valid  = count != '0;
  assign pop_res    = res_valid && res_ready;
  assign res        = res_buf[rd_ptr];

  always_comb begin
    // chunk already at max size (limit lowered mid-chunk)
    close_a = (pos != '0) && (CW'(pos) >= CW'(cfg.max_size));
    pos_a   = close_a ? '0 : pos;
    fp_a    = close_a ? '0 : fp;
    fp_on   = CW'(pos_a) >= CW'(cfg.min_size);
    fp_sh   = {fp_a[62:0], 1'b0} + item.gear;
    mask    = (CW'(pos_a) < CW'(cfg.normal_size)) ? cfg.strict_mask : cfg.loose_mask;
    cut     = fp_on && (pos_a != '0) && ((fp_sh & mask) == '0);
    pos_b   = cut ? '0 : pos_a;
    if (cut) begin
      fp_b = (cfg.min_size == '0) ? item.gear : '0;
    end else begin
      fp_b = fp_on ? fp_sh : fp_a;
    end
    pos_c    = pos_b + 1'b1;
    close_b  = item.eos || (CW'(pos_c) >= CW'(cfg.max_size));
    first_v  = close_a || cut;
    pos_next = close_b ? '0 : pos_c;
    fp_next  = close_b ? '0 : fp_b;

    first_r.chunk_length  = 16'(pos);
    first_r.end_cause     = close_a ? ngc_pkg::CAUSE_MAX : ngc_pkg::CAUSE_CUT;
    first_r.last_of_run   = !close_b;
    second_r.chunk_length = 16'(pos_c);
    second_r.end_cause    = item.eos ? ngc_pkg::CAUSE_END : ngc_pkg::CAUSE_MAX;
    second_r.last_of_run  = 1'b1;
    n_res = 2'(first_v) + 2'(close_b);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (first_v) begin
        res_buf[wr_ptr] <= first_r;
        if (close_b) begin
          res_buf[wr_ptr + 1'b1] <= second_r;
        end
      end else if (close_b) begin
        res_buf[wr_ptr] <= second_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp     <= '0;
      pos    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        fp     <= fp_next;
        pos    <= pos_next;
        wr_ptr <= wr_ptr + ngc_pkg::RES_PTR_BITS'(n_res);
      end
      if (pop_res) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (ngc_pkg::RES_PTR_BITS+1)'(take ? n_res : 2'd0)
                     - (ngc_pkg::RES_PTR_BITS+1)'(pop_res);
    end
  end

endmodule
`default_nettype wire

FILE: design/normalized_gear_chunker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// normalized_gear_chunker
// Content-defined chunker: gear fingerprint with strict and loose cut masks.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_axis   in         data byte or gear table word (tuser = kind)
//  m_axis   out        chunk length and end cause (tlast = last of item)
//  cfg      in         register index and value
//
//  One item accepted per cycle unless a side stalls; a result passes the
//  lookup register, the queue and the result buffer. A byte that closes two
//  chunks yields two results; the back end waits whenever its four-entry
//  result buffer has fewer than two free slots. Either side may stall; the
//  two-entry queue decouples lookup and chunking. Reset clears chunk state;
//  the gear table has no clearing pass and must be loaded before data.
// ----------------------------------------------------------------------------
module normalized_gear_chunker #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,  // data_byte, table_index, table_word
  input  wire logic         s_axis_tlast,  // end_of_stream
  input  wire logic         s_axis_tuser,  // opcode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [23:0]       m_axis_tdata,  // chunk_length, end_cause, zero pad
  output logic              m_axis_tlast,  // last_of_run
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  ngc_pkg::cfg_t        cfg;
  ngc_pkg::gear_item_t  front_item;
  ngc_pkg::gear_item_t  back_item;
  ngc_pkg::result_t     res;
  logic                 front_valid;
  logic                 front_ready;
  logic                 back_valid;
  logic                 back_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_size    <= ngc_pkg::MIN_SIZE_RST;
      cfg.normal_size <= ngc_pkg::NORMAL_SIZE_RST;
      cfg.max_size    <= ngc_pkg::MAX_SIZE_RST;
      cfg.strict_mask <= ngc_pkg::STRICT_MASK_RST;
      cfg.loose_mask  <= ngc_pkg::LOOSE_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ngc_pkg::REG_MIN_SIZE:    cfg.min_size    <= cfg_data[15:0];
        ngc_pkg::REG_NORMAL_SIZE: cfg.normal_size <= cfg_data[15:0];
        ngc_pkg::REG_MAX_SIZE:    cfg.max_size    <= cfg_data[15:0];
        ngc_pkg::REG_STRICT_MASK: cfg.strict_mask <= cfg_data;
        ngc_pkg::REG_LOOSE_MASK:  cfg.loose_mask  <= cfg_data;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  ngc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .opcode        (s_axis_tuser),
    .data_byte     (s_axis_tdata[7:0]),
    .end_of_stream (s_axis_tlast),
    .table_index   (s_axis_tdata[15:8]),
    .table_word    (s_axis_tdata[79:16]),
    .item_valid    (front_valid),
    .item_ready    (front_ready),
    .item          (front_item)
  );

  ngc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_item  (front_item),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_item  (back_item)
  );

  ngc_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .item       (back_item),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tdata = {6'b0, res.end_cause, res.chunk_length};
  assign m_axis_tlast = res.last_of_run;

endmodule
`default_nettype wire

FILE: tb/sv/tb_normalized_gear_chunker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normalized_gear_chunker
// Self-checking bench for the gear chunker: a local predictor follows every
// accepted byte and table load; each returned chunk is matched against the
// oldest predicted one while both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_normalized_gear_chunker;

  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 50;
  localparam int PHASE_ITEMS    = 140;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;  // data_byte, table_index, table_word
  logic         s_axis_tlast = 1'b0;  // end_of_stream
  logic         s_axis_tuser = 1'b0;  // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;  // chunk_length, end_cause, zero pad
  logic         m_axis_tlast;  // last_of_run
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  // Predictor state
  ngc_pkg::cfg_t     shadow_cfg;
  logic [63:0]       gear_mem [256];
  logic [63:0]       fp_state;
  logic [15:0]       chunk_pos;
  ngc_pkg::result_t  pending_chunks [$];

  int mismatch_count = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  int idle_cycles = 0;

  normalized_gear_chunker DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // Mostly random waits, with calm stretches where a side never idles
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [63:0] sparse_mask(input int ones);
    logic [63:0] m;
    m = '0;
    repeat (ones) m[$urandom_range(0, 63)] = 1'b1;
    return m;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Advance the chunk state by one data byte and queue the chunks it closes
  function automatic void predict_chunks(input logic [7:0] b, input logic eos);
    logic [15:0]       pos;
    logic [63:0]       mask;
    ngc_pkg::result_t  closed [$];
    ngc_pkg::result_t  r;
    pos = chunk_pos;
    r.last_of_run = 1'b0;
    if (pos > 0 && pos >= shadow_cfg.max_size) begin
      r.chunk_length = pos;
      r.end_cause = ngc_pkg::CAUSE_MAX;
      closed.push_back(r);
      pos = '0;
      fp_state = '0;
    end
    if (pos >= shadow_cfg.min_size) begin
      fp_state = (fp_state << 1) + gear_mem[b];
      mask = (pos < shadow_cfg.normal_size) ? shadow_cfg.strict_mask : shadow_cfg.loose_mask;
      if (pos > 0 && (fp_state & mask) == '0) begin
        r.chunk_length = pos;
        r.end_cause = ngc_pkg::CAUSE_CUT;
        closed.push_back(r);
        pos = '0;
        // the cutting byte opens the next chunk, fingerprinted when min is zero
        fp_state = (shadow_cfg.min_size == '0) ? gear_mem[b] : '0;
      end
    end
    pos = pos + 16'd1;
    if (eos) begin
      r.chunk_length = pos;
      r.end_cause = ngc_pkg::CAUSE_END;
      closed.push_back(r);
      pos = '0;
      fp_state = '0;
    end else if (pos >= shadow_cfg.max_size) begin
      r.chunk_length = pos;
      r.end_cause = ngc_pkg::CAUSE_MAX;
      closed.push_back(r);
      pos = '0;
      fp_state = '0;
    end
    chunk_pos = pos;
    foreach (closed[i]) begin
      r = closed[i];
      r.last_of_run = (i == closed.size() - 1);
      pending_chunks.push_back(r);
    end
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b, input logic eos,
                           input logic [7:0] idx, input logic [63:0] word);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {word, idx, b};
    s_axis_tlast  <= eos;
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (op == ngc_pkg::OP_LOAD) gear_mem[idx] = word;
    else predict_chunks(b, eos);
  endtask

  // Data byte with random don't-care load fields
  task automatic send_byte(input logic [7:0] b, input logic eos);
    send_item(ngc_pkg::OP_DATA, b, eos, 8'($urandom), rand_word());
  endtask

  task automatic send_load(input logic [7:0] idx, input logic [63:0] word);
    send_item(ngc_pkg::OP_LOAD, 8'($urandom), 1'($urandom), idx, word);
  endtask

  // Hold the stream until every chunk is back and the pipeline has emptied
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_chunks.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    wait_idle();
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ngc_pkg::REG_MIN_SIZE:    shadow_cfg.min_size    = value[15:0];
      ngc_pkg::REG_NORMAL_SIZE: shadow_cfg.normal_size = value[15:0];
      ngc_pkg::REG_MAX_SIZE:    shadow_cfg.max_size    = value[15:0];
      ngc_pkg::REG_STRICT_MASK: shadow_cfg.strict_mask = value;
      ngc_pkg::REG_LOOSE_MASK:  shadow_cfg.loose_mask  = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] min_sz, input logic [15:0] normal_sz,
                            input logic [15:0] max_sz, input logic [63:0] strict_m,
                            input logic [63:0] loose_m);
    write_reg(ngc_pkg::REG_MIN_SIZE, 64'(min_sz));
    write_reg(ngc_pkg::REG_NORMAL_SIZE, 64'(normal_sz));
    write_reg(ngc_pkg::REG_MAX_SIZE, 64'(max_sz));
    write_reg(ngc_pkg::REG_STRICT_MASK, strict_m);
    write_reg(ngc_pkg::REG_LOOSE_MASK, loose_m);
  endtask

  task automatic load_gear_table();
    for (int i = 0; i < 256; i++) begin
      if (i == 0) send_load(8'(i), '0);
      else if (i == 255) send_load(8'(i), '1);
      else send_load(8'(i), rand_word());
    end
  endtask

  // Reset sizes: no fingerprinting yet, so only end of stream closes
  task automatic test_reset_config();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_load(8'h80, rand_word());
    send_byte(8'h5a, 1'b1);
  endtask

  // Zero strict mask with min zero: every byte past the first cuts
  task automatic test_cut_every_byte();
    set_config(16'd0, 16'hffff, 16'hffff, '0, '1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    // cut and end of stream on one byte
    send_byte(8'h55, 1'b1);
  endtask

  task automatic test_max_and_end();
    set_config(16'hffff, 16'hffff, 16'd3, '1, '1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b1);
  endtask

  // Lower max below the open chunk: it closes before the next byte
  task automatic test_max_lowered();
    set_config(16'hffff, 16'hffff, 16'hffff, '1, '1);
    repeat (4) send_byte(8'($urandom), 1'b0);
    write_reg(ngc_pkg::REG_MAX_SIZE, 64'd2);
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_max_zero();
    write_reg(ngc_pkg::REG_MAX_SIZE, 64'd0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_random_phases();
    logic [15:0] min_sz, normal_sz, max_sz;
    logic [63:0] strict_m, loose_m;
    int          eos_odds;
    for (int p = 0; p < 8; p++) begin
      eos_odds = 40;
      min_sz = 16'($urandom_range(0, 6));
      normal_sz = min_sz + 16'($urandom_range(0, 12));
      max_sz = normal_sz + 16'($urandom_range(1, 24));
      strict_m = sparse_mask($urandom_range(3, 5));
      loose_m = sparse_mask($urandom_range(1, 2));
      case (p)
        3: begin
          min_sz = 16'd0;
          normal_sz = 16'($urandom_range(0, 4));
          max_sz = 16'($urandom_range(8, 30));
          strict_m = sparse_mask(2);
          loose_m = sparse_mask(1);
        end
        4: begin
          // normal below min: loose mask from the first fingerprinted byte
          min_sz = 16'($urandom_range(5, 10));
          normal_sz = 16'($urandom_range(0, 4));
          max_sz = 16'($urandom_range(20, 40));
          strict_m = sparse_mask(2);
        end
        5: begin
          min_sz = 16'($urandom_range(0, 3));
          normal_sz = 16'($urandom_range(4, 10));
          max_sz = 16'($urandom_range(30, 50));
          strict_m = '1;
          loose_m = '0;
        end
        6: begin
          min_sz = 16'hffff;
          normal_sz = 16'hffff;
          max_sz = 16'hffff;
          strict_m = '1;
          loose_m = '1;
          eos_odds = 8;
        end
        7: begin
          min_sz = 16'd0;
          normal_sz = 16'hffff;
          max_sz = 16'hffff;
          strict_m = sparse_mask(3);
          loose_m = '1;
        end
        default: ;
      endcase
      set_config(min_sz, normal_sz, max_sz, strict_m, loose_m);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 19) == 0) send_load(8'($urandom), rand_word());
        else send_byte(8'($urandom), ($urandom_range(1, eos_odds) == 1));
      end
    end
  endtask

  // Result side: random stalls, field-by-field check against the oldest chunk
  initial begin : chunk_monitor
    int                stall;
    ngc_pkg::result_t  want;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(rx_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_chunks.size() == 0) begin
        report_mismatch($sformatf("unexpected chunk length %0d cause %0d",
                                  m_axis_tdata[15:0], m_axis_tdata[17:16]));
      end else begin
        want = pending_chunks.pop_front();
        if (m_axis_tdata[15:0] !== want.chunk_length)
          report_mismatch($sformatf("chunk_length got %0d want %0d",
                                    m_axis_tdata[15:0], want.chunk_length));
        if (m_axis_tdata[17:16] !== want.end_cause)
          report_mismatch($sformatf("end_cause got %0d want %0d",
                                    m_axis_tdata[17:16], want.end_cause));
        if (m_axis_tlast !== want.last_of_run)
          report_mismatch($sformatf("last_of_run got %0b want %0b",
                                    m_axis_tlast, want.last_of_run));
      end
    end
  end

  // End the run when no channel has moved an item for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    shadow_cfg.min_size    = ngc_pkg::MIN_SIZE_RST;
    shadow_cfg.normal_size = ngc_pkg::NORMAL_SIZE_RST;
    shadow_cfg.max_size    = ngc_pkg::MAX_SIZE_RST;
    shadow_cfg.strict_mask = ngc_pkg::STRICT_MASK_RST;
    shadow_cfg.loose_mask  = ngc_pkg::LOOSE_MASK_RST;
    fp_state  = '0;
    chunk_pos = '0;
    foreach (gear_mem[i]) gear_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_gear_table();
    test_reset_config();
    test_cut_every_byte();
    test_max_and_end();
    test_max_lowered();
    test_max_zero();
    test_random_phases();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ngc_pkg.sv
design/ngc_front.sv
design/ngc_queue.sv
design/ngc_back.sv
design/normalized_gear_chunker.sv
tb/sv/tb_normalized_gear_chunker.sv
